[rtl/core/distance_vector_route_table_macros.svh]
// assertion macros for the distance-vector route table
// used by the top level only, expects clk and rst_n in scope
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_MACROS_SVH

// same-cycle implication
`define DVRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dvrt assertion failed");

// next-cycle implication
`define DVRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dvrt assertion failed");

`endif

[rtl/core/dvrt_pkg.sv]
// types and constants of the distance-vector route table
// no dependencies
`default_nettype none
package dvrt_pkg;

  localparam int SLOT_W    = 6;
  localparam int IFACE_W   = 5;
  localparam int ADDR_W    = 32;
  localparam int COST_W    = 8;
  localparam int AGE_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_INFINITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE   = 1'b1;

  typedef enum logic [2:0] {
    ACT_UPDATE   = 3'd0,
    ACT_LOOKUP   = 3'd1,
    ACT_TICK     = 3'd2,
    ACT_DOWN     = 3'd3,
    ACT_ANNOUNCE = 3'd4
  } act_t;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } st_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [ADDR_W-1:0]  dest_addr;
    logic [COST_W-1:0]  cost;
    logic [IFACE_W-1:0] iface;
  } in_t;

  typedef struct packed {
    logic               status;
    logic               changed;
    logic               found;
    logic [IFACE_W-1:0] route_iface;
    logic [ADDR_W-1:0]  entry_addr;
    logic [COST_W-1:0]  entry_cost;
    logic               last;
  } out_t;

  // command as held during a sweep, cost already clamped
  typedef struct packed {
    logic [2:0]         action;
    logic [ADDR_W-1:0]  dest;
    logic [COST_W-1:0]  cost;
    logic [IFACE_W-1:0] ifc;
  } cmd_t;

  // token handed from cell to cell
  typedef struct packed {
    logic               active;
    logic               matched;
    logic               changed;
    logic               found;
    logic [IFACE_W-1:0] riface;
    logic               free_seen;
    logic [SLOT_W-1:0]  free_idx;
    logic               pend_valid;
    logic [ADDR_W-1:0]  pend_addr;
    logic [COST_W-1:0]  pend_cost;
  } tok_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [COST_W-1:0] cost;
  } emit_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  idx;
    logic [ADDR_W-1:0]  dest;
    logic [COST_W-1:0]  cost;
    logic [IFACE_W-1:0] iface;
  } wr_t;

endpackage
`default_nettype wire

[rtl/core/dvrt_cell.sv]
// one route table entry and its share of a sweep
// depends on dvrt_pkg
`default_nettype none
module dvrt_cell import dvrt_pkg::*; #(
  parameter int INDEX      = 0,
  parameter int NUM_IFACES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire cmd_t              cmd,
  input  wire logic [COST_W-1:0] inf_cost,
  input  wire logic [AGE_W-1:0]  expire,
  input  wire wr_t               wr,
  input  wire tok_t              tok_in,
  output tok_t                   tok_out,
  output emit_t                  emit
);

  localparam logic [IFACE_W-1:0] NONE = IFACE_W'(NUM_IFACES);
  localparam logic [SLOT_W-1:0]  SLOT = SLOT_W'(INDEX);

  tok_t               tok_r;
  logic               valid_r, valid_nxt;
  logic [ADDR_W-1:0]  dest_r, dest_nxt;
  logic [COST_W-1:0]  cost_r, cost_nxt;
  logic [IFACE_W-1:0] iface_r, iface_nxt;
  logic [AGE_W-1:0]   age_r, age_nxt;
  logic [AGE_W-1:0]   age_inc;
  logic               hit;
  tok_t               t;

  always_comb begin
    t         = tok_r;
    emit      = '0;
    valid_nxt = valid_r;
    dest_nxt  = dest_r;
    cost_nxt  = cost_r;
    iface_nxt = iface_r;
    age_nxt   = age_r;
    hit       = valid_r && (dest_r == cmd.dest);
    age_inc   = (age_r == {AGE_W{1'b1}}) ? age_r : age_r + 1'b1;
    if (step && tok_r.active) begin
      case (cmd.action)
        ACT_UPDATE: begin
          if (hit) begin
            t.matched = 1'b1;
            if (iface_r == cmd.ifc) begin
              if (cost_r != cmd.cost) begin
                cost_nxt  = cmd.cost;
                t.changed = 1'b1;
              end
              age_nxt = '0;
            end else if (cost_r > cmd.cost) begin
              cost_nxt  = cmd.cost;
              iface_nxt = cmd.ifc;
              age_nxt   = '0;
              t.changed = 1'b1;
            end
          end else if (!valid_r && !tok_r.free_seen) begin
            t.free_seen = 1'b1;
            t.free_idx  = SLOT;
          end
        end
        ACT_LOOKUP: begin
          if (hit && cost_r < inf_cost) begin
            t.found  = 1'b1;
            t.riface = iface_r;
          end
        end
        ACT_TICK: begin
          if (valid_r) begin
            age_nxt = age_inc;
            if (age_inc >= expire && cost_r != inf_cost) begin
              cost_nxt  = inf_cost;
              t.changed = 1'b1;
            end
          end
        end
        ACT_DOWN: begin
          if (valid_r && iface_r == cmd.ifc && cost_r != inf_cost) begin
            cost_nxt  = inf_cost;
            t.changed = 1'b1;
          end
        end
        ACT_ANNOUNCE: begin
          if (valid_r) begin
            emit.valid   = tok_r.pend_valid;
            emit.addr    = tok_r.pend_addr;
            emit.cost    = tok_r.pend_cost;
            t.pend_valid = 1'b1;
            t.pend_addr  = dest_r;
            t.pend_cost  = (iface_r != NONE && iface_r == cmd.ifc) ? inf_cost : cost_r;
          end
        end
        default: begin
        end
      endcase
    end
    if (wr.en && wr.idx == SLOT) begin
      valid_nxt = 1'b1;
      dest_nxt  = wr.dest;
      cost_nxt  = wr.cost;
      iface_nxt = wr.iface;
      age_nxt   = '0;
    end
    tok_out = t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (step) tok_r <= tok_in;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dest_r  <= dest_nxt;
    cost_r  <= cost_nxt;
    iface_r <= iface_nxt;
    age_r   <= age_nxt;
  end

endmodule
`default_nettype wire

[rtl/core/distance_vector_route_table.sv]
// top level of the distance-vector route table: control, chain of entry cells
// depends on dvrt_pkg, dvrt_cell and distance_vector_route_table_macros.svh
//
//   channel  direction  handshake          payload
//   in_      into       in_valid/in_stall  in_data   (in_t)
//   out_     out of     out_valid/out_stall out_data (out_t)
//   cfg_     into       cfg_we             cfg_idx, cfg_wdata
//
// one item at a time; a token walks the cells one per cycle while the output is
// not stalled
// an announce transfer waits on out_stall, the walk pauses with it
// reset clears the valid bits of all entries and sets the control and config registers to defaults
`default_nettype none
`include "distance_vector_route_table_macros.svh"
module distance_vector_route_table import dvrt_pkg::*; #(
  parameter int TABLE_ENTRIES = 32,
  parameter int NUM_IFACES    = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_t                      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic [IFACE_W-1:0] NONE = IFACE_W'(NUM_IFACES);

  st_t               st_r, st_nxt;
  logic [COST_W-1:0] inf_r;
  logic [AGE_W-1:0]  exp_r;
  cmd_t              cmd_r;
  tok_t              hd_r, tl_r;
  out_t              out_r, fin;
  logic              out_valid_r;
  logic              step, accept;
  logic [IFACE_W-1:0] ifc;
  logic [COST_W-1:0] ccost;
  tok_t              link [TABLE_ENTRIES+1];
  emit_t             emit [TABLE_ENTRIES];
  emit_t             emit_any;
  wr_t               wr;
  logic [TABLE_ENTRIES+1:0] tok_act;

  assign step     = !out_valid_r || !out_stall;
  assign accept   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign link[0]   = hd_r;

  always_comb begin
    ifc   = (int'(in_data.iface) > NUM_IFACES) ? NONE : in_data.iface;
    ccost = (in_data.cost >= inf_r) ? inf_r : in_data.cost;
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    dvrt_cell #(
      .INDEX      (k),
      .NUM_IFACES (NUM_IFACES)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (step),
      .cmd      (cmd_r),
      .inf_cost (inf_r),
      .expire   (exp_r),
      .wr       (wr),
      .tok_in   (link[k]),
      .tok_out  (link[k+1]),
      .emit     (emit[k])
    );
  end

  always_comb begin
    emit_any = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) emit_any = emit_t'(emit_any | emit[k]);
  end

  always_comb begin
    for (int k = 0; k < TABLE_ENTRIES; k++) tok_act[k] = link[k+1].active;
    tok_act[TABLE_ENTRIES]   = hd_r.active;
    tok_act[TABLE_ENTRIES+1] = tl_r.active;
  end

  // end of sweep: final result and insert into the first free slot
  always_comb begin
    fin             = '0;
    fin.route_iface = NONE;
    fin.last        = 1'b1;
    wr              = '0;
    wr.idx          = tl_r.free_idx;
    wr.dest         = cmd_r.dest;
    wr.cost         = cmd_r.cost;
    wr.iface        = cmd_r.ifc;
    case (cmd_r.action)
      ACT_UPDATE: begin
        if (tl_r.matched) begin
          fin.changed = tl_r.changed;
        end else if (tl_r.free_seen) begin
          fin.changed = 1'b1;
          wr.en       = step && tl_r.active;
        end else begin
          fin.status = 1'b1;
        end
      end
      ACT_LOOKUP: begin
        fin.found       = tl_r.found;
        fin.route_iface = tl_r.found ? tl_r.riface : NONE;
      end
      ACT_TICK, ACT_DOWN: fin.changed = tl_r.changed;
      ACT_ANNOUNCE: begin
        fin.found      = tl_r.pend_valid;
        fin.entry_addr = tl_r.pend_addr;
        fin.entry_cost = tl_r.pend_cost;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st_nxt   = st_r;
    in_stall = 1'b1;
    case (st_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) st_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (tl_r.active && step) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      inf_r       <= COST_W'(16);
      exp_r       <= AGE_W'(180);
      hd_r        <= '0;
      tl_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_INFINITY: inf_r <= cfg_wdata[COST_W-1:0];
          CFG_EXPIRE:   exp_r <= cfg_wdata[AGE_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        hd_r <= '{active: 1'b1, riface: NONE, default: '0};
      end else if (step) begin
        hd_r <= '0;
      end
      if (step) tl_r <= link[TABLE_ENTRIES];
      if (step && (emit_any.valid || tl_r.active)) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.action <= in_data.action;
      cmd_r.dest   <= in_data.dest_addr;
      cmd_r.cost   <= ccost;
      cmd_r.ifc    <= ifc;
    end
    if (step && emit_any.valid) begin
      out_r <= '{found: 1'b1, route_iface: NONE, entry_addr: emit_any.addr,
                 entry_cost: emit_any.cost, default: '0};
    end else if (step && tl_r.active) begin
      out_r <= fin;
    end
  end

  `DVRT_ASSERT_IMP(a_one_token, 1'b1, $onehot0(tok_act))
  `DVRT_ASSERT_IMP(a_idle_empty, st_r == ST_IDLE, tok_act == '0)
  `DVRT_ASSERT_NXT(a_finish_last, tl_r.active && step, out_valid_r && out_r.last)

endmodule
`default_nettype wire
